// File: rtl/core/rtnh_pkg.sv
package rtnh_pkg;

	// Table geometry default
	localparam int TABLE_ENTRIES_DEF = 16;

	// Field widths
	localparam int MODE_W = 2;
	localparam int ADDR_W = 16;
	localparam int HOPS_W = 8;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

	// Register index of default_next_hop (paddr[2])
	localparam logic REG_DEFAULT_NH = 1'b0;

	// Controller -> datapath commands
	typedef struct packed {
		logic cap;        // latch the accepted item
		logic srch;       // register match / free search
		logic exec;       // table update and entry read
		logic emit_now;   // load result without entry data
		logic emit_read;  // load result from entry read data
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic need_read;  // lookup that hit: result comes from the entry store
	} stat_t;

endpackage

// File: rtl/core/rtnh_ctrl.sv
module rtnh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rtnh_pkg::stat_t stat,
	output rtnh_pkg::cmd_t  cmd,
	output logic           busy
);
	import rtnh_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SRCH = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_nxt = ST_SRCH;
				end
			end
			ST_SRCH: begin
				cmd.srch = 1'b1;
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.need_read) begin
					state_nxt = ST_RESP;
				end else begin
					cmd.emit_now = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_RESP: begin
				cmd.emit_read = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

`ifndef ASSERT_OFF
	a_cap_to_srch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> (state_q == ST_SRCH))
		else $error("accepted item did not enter search");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_now && cmd.emit_read))
		else $error("two result loads in one cycle");
	a_read_path: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_read |-> $past(cmd.exec))
		else $error("entry-data result without a preceding read");
`endif

endmodule

// File: rtl/core/rtnh_dp.sv
module rtnh_dp #(
	parameter int TABLE_ENTRIES = rtnh_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rtnh_pkg::cmd_t                cmd,
	output rtnh_pkg::stat_t               stat,
	input  logic [rtnh_pkg::MODE_W-1:0]   mode,
	input  logic [rtnh_pkg::ADDR_W-1:0]   dest_addr,
	input  logic [rtnh_pkg::HOPS_W-1:0]   hop_count,
	input  logic [rtnh_pkg::ADDR_W-1:0]   next_hop_in,
	input  logic [rtnh_pkg::ADDR_W-1:0]   default_nh,
	output logic                          done,
	output logic [rtnh_pkg::ADDR_W-1:0]   next_hop_out,
	output logic [rtnh_pkg::HOPS_W-1:0]   hops_out,
	output logic                          hit,
	output logic                          status
);
	import rtnh_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int DW = HOPS_W + ADDR_W;

	// Captured item
	logic [MODE_W-1:0] mode_q;
	logic [ADDR_W-1:0] dest_q;
	logic [HOPS_W-1:0] hops_q;
	logic [ADDR_W-1:0] nh_q;

	// Table: valid bits and destination tags in flops, payload in a memory
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [ADDR_W-1:0]        tag_q [TABLE_ENTRIES];
	logic [DW-1:0]            mem [TABLE_ENTRIES];
	logic [DW-1:0]            rd_q;

	// Search results
	logic          found_q;
	logic          full_q;
	logic [IW-1:0] match_idx_q;
	logic [IW-1:0] free_idx_q;

	logic [TABLE_ENTRIES-1:0] match_vec;
	logic [TABLE_ENTRIES-1:0] free_oh;
	logic [IW-1:0]            match_idx;
	logic [IW-1:0]            free_idx;

	logic          wr_upd, wr_new, wr_en, del_en;
	logic [IW-1:0] wr_idx;

	logic                done_q;
	logic [ADDR_W-1:0]   res_nh_q;
	logic [HOPS_W-1:0]   res_hops_q;
	logic                res_hit_q;
	logic                res_status_q;

	// Index of the set bit of a one-hot (or empty) vector
	function automatic logic [IW-1:0] oh_enc(input logic [TABLE_ENTRIES-1:0] v);
		logic [IW-1:0] r;
		r = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (v[i]) begin
				r = r | IW'(i);
			end
		end
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (tag_q[i] == dest_q);
		end
	end

	// lowest clear valid bit, empty when the table is full
	assign free_oh   = ~valid_q & (valid_q + TABLE_ENTRIES'(1));
	assign match_idx = oh_enc(match_vec);
	assign free_idx  = oh_enc(free_oh);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q <= mode;
			dest_q <= dest_addr;
			hops_q <= hop_count;
			nh_q   <= next_hop_in;
		end
		if (cmd.srch) begin
			found_q     <= |match_vec;
			full_q      <= &valid_q;
			match_idx_q <= match_idx;
			free_idx_q  <= free_idx;
		end
	end

	assign stat.need_read = found_q && (mode_q == MODE_LOOKUP);

	assign wr_upd = cmd.exec && (mode_q == MODE_ADD) && found_q;
	assign wr_new = cmd.exec && (mode_q == MODE_ADD) && !found_q && !full_q;
	assign wr_en  = wr_upd || wr_new;
	assign wr_idx = found_q ? match_idx_q : free_idx_q;
	assign del_en = cmd.exec && (mode_q == MODE_DELETE) && found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (wr_new && (free_idx_q == IW'(i))) begin
					valid_q[i] <= 1'b1;
				end else if (del_en && (match_idx_q == IW'(i))) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (wr_new && (free_idx_q == IW'(i))) begin
				tag_q[i] <= dest_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {hops_q, nh_q};
		end
		if (cmd.exec) begin
			rd_q <= mem[match_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_read) begin
			res_hops_q   <= rd_q[DW-1:ADDR_W];
			res_nh_q     <= rd_q[ADDR_W-1:0];
			res_hit_q    <= 1'b1;
			res_status_q <= 1'b0;
		end else if (cmd.emit_now) begin
			res_hops_q   <= '0;
			res_nh_q     <= (mode_q == MODE_LOOKUP) ? default_nh : '0;
			res_hit_q    <= found_q && ((mode_q == MODE_ADD) || (mode_q == MODE_DELETE));
			res_status_q <= (mode_q == MODE_ADD) && !found_q && full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_now || cmd.emit_read;
		end
	end

	assign done         = done_q;
	assign next_hop_out = res_nh_q;
	assign hops_out     = res_hops_q;
	assign hit          = res_hit_q;
	assign status       = res_status_q;

`ifndef ASSERT_OFF
	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch |-> $onehot0(match_vec))
		else $error("destination held by more than one entry");
	a_full_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch |-> ((&valid_q) == (free_oh == '0)))
		else $error("free-slot search disagrees with full flag");
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(res_hit_q && res_status_q))
		else $error("result both hit and dropped");
`endif

endmodule

// File: rtl/core/route_table_next_hop.sv
// route_table_next_hop: small next-hop routing table with a default route.
//
// Command channel: present mode/dest_addr/hop_count/next_hop_in with start;
// the item is taken on the clock edge where start is high and busy is low.
// Modes: lookup (next hop and hop count, or the default next hop on a
// miss), add/update (update the matching entry, else fill the lowest free
// entry, else drop and set status), delete (clear the matching entry).
// Result channel: done is high for exactly one cycle with next_hop_out,
// hops_out, hit and status valid in that cycle. The receiver cannot stall;
// results stay on the ports until the next item overwrites them.
// Sequence: the controller steps through search and execute, and for lookup
// hits through a respond state for the registered read of the entry payload
// memory; done is registered from the last of these. busy drops with done,
// so a new item is taken only after the result of the previous one; the
// search / update / respond sequence of the controller paces the items.
// Configuration: APB register 0 (paddr[2] = 0, byte addresses 0 to 3) holds
// default_next_hop in bits 15:0; writes with paddr[2] set are ignored. pready is tied high.
// Reset: all entries invalid, default_next_hop = 0, controller idle.
module route_table_next_hop #(
	parameter int TABLE_ENTRIES = rtnh_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic [rtnh_pkg::MODE_W-1:0] mode,
	input  logic [rtnh_pkg::ADDR_W-1:0] dest_addr,
	input  logic [rtnh_pkg::HOPS_W-1:0] hop_count,
	input  logic [rtnh_pkg::ADDR_W-1:0] next_hop_in,
	// result channel
	output logic                        done,
	output logic [rtnh_pkg::ADDR_W-1:0] next_hop_out,
	output logic [rtnh_pkg::HOPS_W-1:0] hops_out,
	output logic                        hit,
	output logic                        status,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import rtnh_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	logic [ADDR_W-1:0] default_nh_q;
	logic              cfg_wr;

	// register write on the APB access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_nh_q <= '0;
		end else if (cfg_wr && (paddr[2] == REG_DEFAULT_NH)) begin
			default_nh_q <= pwdata[ADDR_W-1:0];
		end
	end

	// read-back; unmapped address reads as zero
	assign prdata = (paddr[2] == REG_DEFAULT_NH) ? {{(32-ADDR_W){1'b0}}, default_nh_q} : '0;

	rtnh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rtnh_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.dest_addr    (dest_addr),
		.hop_count    (hop_count),
		.next_hop_in  (next_hop_in),
		.default_nh   (default_nh_q),
		.done         (done),
		.next_hop_out (next_hop_out),
		.hops_out     (hops_out),
		.hit          (hit),
		.status       (status)
	);

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while an item is still in work");
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in work");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");
`endif

endmodule
